@@ rtl/dlf_pkg.sv @@
// Shared constants, item types and control structs for the dense layer forward block.
package dlf_pkg;

  localparam int NUM_FEATURES = 64;
  localparam int NUM_CLASSES  = 16;

  localparam int FEAT_W = 6;
  localparam int CLS_W  = 4;
  localparam int VAL_W  = 16;
  localparam int PROD_W = 2 * VAL_W;
  localparam int ACC_W  = 40;
  localparam int SUM_W  = ACC_W + 2;
  localparam int FRAC_W = 8;

  localparam int ACT_CLASSES = (NUM_CLASSES < (1 << CLS_W)) ? NUM_CLASSES : (1 << CLS_W);
  localparam int WDEPTH      = NUM_FEATURES * NUM_CLASSES;
  localparam int WADDR_W     = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
  localparam int CIDX_W      = (ACT_CLASSES > 1) ? $clog2(ACT_CLASSES) : 1;

  localparam logic [1:0] REQ_WEIGHT  = 2'd0;
  localparam logic [1:0] REQ_BIAS    = 2'd1;
  localparam logic [1:0] REQ_FEATURE = 2'd2;

  typedef struct packed {
    logic [1:0]              req_type;
    logic [FEAT_W-1:0]       feature_index;
    logic [CLS_W-1:0]        class_index_in;
    logic signed [VAL_W-1:0] value;
    logic                    last_feature;
  } dlf_req_t;

  typedef struct packed {
    logic [CLS_W-1:0]        class_index;
    logic signed [VAL_W-1:0] score;
    logic                    last_result;
  } dlf_res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_EMIT
  } dlf_state_e;

  typedef struct packed {
    logic              mac_issue;
    logic              emit_issue;
    logic [CIDX_W-1:0] cls;
    logic              last_cls;
  } dlf_ctl_t;

  typedef struct packed {
    logic pipe_busy;
  } dlf_sts_t;

endpackage

@@ rtl/dlf_ram.sv @@
// Generic simple dual-port synchronous RAM with registered read data.
module dlf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/dlf_ctrl.sv @@
// Sequencer: walks the classes for accumulation, waits for write-back, then walks emission for an element marked last.
module dlf_ctrl
  import dlf_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     accept_i,
  input  dlf_req_t req_i,
  input  dlf_sts_t sts_i,
  output dlf_ctl_t ctl_o,
  output logic     busy_o
);

  localparam logic [CIDX_W-1:0] KMAX = CIDX_W'(ACT_CLASSES - 1);

  dlf_state_e        state_q, state_d;
  logic [CIDX_W-1:0] k_q, k_d;
  logic              last_q, last_d;
  logic              in_range;

  assign in_range = (int'(req_i.feature_index) < NUM_FEATURES);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      k_q     <= '0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      last_q  <= last_d;
    end
  end

  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    last_d  = last_q;
    ctl_o   = '0;
    ctl_o.cls = k_q;
    case (state_q)
      ST_IDLE: begin
        if (accept_i && req_i.req_type == REQ_FEATURE) begin
          k_d    = '0;
          last_d = req_i.last_feature;
          if (in_range) begin
            state_d = ST_MAC;
          end else if (req_i.last_feature) begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_MAC: begin
        ctl_o.mac_issue = 1'b1;
        if (k_q == KMAX) begin
          state_d = ST_DRAIN;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (!sts_i.pipe_busy) begin
          k_d     = '0;
          state_d = last_q ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        ctl_o.emit_issue = 1'b1;
        ctl_o.last_cls   = (k_q == KMAX);
        if (k_q == KMAX) begin
          state_d = ST_IDLE;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

@@ rtl/dlf_datapath.sv @@
// Weight, bias and accumulator memories with the shared MAC and the round/saturate output path.
module dlf_datapath
  import dlf_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     accept_i,
  input  dlf_req_t req_i,
  input  dlf_ctl_t ctl_i,
  output dlf_sts_t sts_o,
  output logic     res_valid_o,
  output dlf_res_t res_o
);

  logic signed [VAL_W-1:0] x_q;
  logic [FEAT_W-1:0]       f_q;

  logic                    w_we;
  logic [WADDR_W-1:0]      w_waddr, w_raddr;
  logic [VAL_W-1:0]        w_rdata;
  logic                    b_we;
  logic [VAL_W-1:0]        b_rdata;
  logic                    a_we;
  logic [ACC_W-1:0]        a_wdata, a_rdata;
  logic                    rd_en;

  logic [ACT_CLASSES-1:0]  acc_vld_q;
  logic                    rd_vld_q;
  logic [ACC_W-1:0]        acc_eff;

  logic                    s1_v_q, s2_v_q;
  logic [CIDX_W-1:0]       s1_k_q, s2_k_q;
  logic signed [PROD_W-1:0] p_d, p_q;
  logic [ACC_W-1:0]        a_q;

  logic                    e1_v_q, e2_v_q;
  logic [CIDX_W-1:0]       e1_k_q, e2_k_q;
  logic                    e1_last_q, e2_last_q;
  logic signed [ACC_W-1:0] acc_s;
  logic signed [VAL_W-1:0] bias_s;
  logic signed [SUM_W-1:0] sum_d, sum_q;
  logic [SUM_W-FRAC_W-1:0] q_w;
  logic                    q_fits;
  logic [VAL_W-1:0]        score_d;

  logic                    res_v_q;
  dlf_res_t                res_q;

  assign w_we = accept_i && req_i.req_type == REQ_WEIGHT
             && int'(req_i.feature_index) < NUM_FEATURES
             && int'(req_i.class_index_in) < NUM_CLASSES;
  assign w_waddr = WADDR_W'(int'(req_i.feature_index) * NUM_CLASSES
                            + int'(req_i.class_index_in));
  assign w_raddr = WADDR_W'(int'(f_q) * NUM_CLASSES + int'(ctl_i.cls));
  assign b_we = accept_i && req_i.req_type == REQ_BIAS
             && int'(req_i.class_index_in) < ACT_CLASSES;
  assign rd_en = ctl_i.mac_issue || ctl_i.emit_issue;

  dlf_ram #(.WIDTH(VAL_W), .DEPTH(WDEPTH)) u_weight_ram (
    .clk_i   (clk_i),
    .we_i    (w_we),
    .waddr_i (w_waddr),
    .wdata_i (req_i.value),
    .re_i    (ctl_i.mac_issue),
    .raddr_i (w_raddr),
    .rdata_o (w_rdata)
  );

  dlf_ram #(.WIDTH(VAL_W), .DEPTH(ACT_CLASSES)) u_bias_ram (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i (CIDX_W'(req_i.class_index_in)),
    .wdata_i (req_i.value),
    .re_i    (ctl_i.emit_issue),
    .raddr_i (ctl_i.cls),
    .rdata_o (b_rdata)
  );

  dlf_ram #(.WIDTH(ACC_W), .DEPTH(ACT_CLASSES)) u_acc_ram (
    .clk_i   (clk_i),
    .we_i    (a_we),
    .waddr_i (s2_k_q),
    .wdata_i (a_wdata),
    .re_i    (rd_en),
    .raddr_i (ctl_i.cls),
    .rdata_o (a_rdata)
  );

  // Accumulator entries read as zero until written after reset or emission.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_vld_q <= '0;
      s1_v_q    <= 1'b0;
      s2_v_q    <= 1'b0;
      e1_v_q    <= 1'b0;
      e2_v_q    <= 1'b0;
      res_v_q   <= 1'b0;
    end else begin
      if (a_we) begin
        acc_vld_q[s2_k_q] <= 1'b1;
      end
      if (ctl_i.emit_issue) begin
        acc_vld_q[ctl_i.cls] <= 1'b0;
      end
      s1_v_q  <= ctl_i.mac_issue;
      s2_v_q  <= s1_v_q;
      e1_v_q  <= ctl_i.emit_issue;
      e2_v_q  <= e1_v_q;
      res_v_q <= e2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && req_i.req_type == REQ_FEATURE) begin
      x_q <= req_i.value;
      f_q <= req_i.feature_index;
    end
    if (rd_en) begin
      rd_vld_q <= acc_vld_q[ctl_i.cls];
    end
    s1_k_q    <= ctl_i.cls;
    s2_k_q    <= s1_k_q;
    p_q       <= p_d;
    a_q       <= acc_eff;
    e1_k_q    <= ctl_i.cls;
    e1_last_q <= ctl_i.last_cls;
    e2_k_q    <= e1_k_q;
    e2_last_q <= e1_last_q;
    sum_q     <= sum_d;
    res_q.class_index <= CLS_W'(e2_k_q);
    res_q.score       <= score_d;
    res_q.last_result <= e2_last_q;
  end

  assign acc_eff = rd_vld_q ? a_rdata : '0;
  assign p_d     = x_q * $signed(w_rdata);
  assign a_we    = s2_v_q;
  assign a_wdata = a_q + ACC_W'(p_q);

  // sum = acc + bias * 256 + 128, then floor shift and saturate to Q8.8
  assign acc_s  = $signed(acc_eff);
  assign bias_s = $signed(b_rdata);
  assign sum_d  = SUM_W'(acc_s) + (SUM_W'(bias_s) <<< FRAC_W)
                + SUM_W'(1 << (FRAC_W - 1));
  assign q_w    = sum_q[SUM_W-1:FRAC_W];
  assign q_fits = (&q_w[SUM_W-FRAC_W-1:VAL_W-1]) || !(|q_w[SUM_W-FRAC_W-1:VAL_W-1]);

  always_comb begin
    if (q_fits) begin
      score_d = q_w[VAL_W-1:0];
    end else if (q_w[SUM_W-FRAC_W-1]) begin
      score_d = {1'b1, {(VAL_W-1){1'b0}}};
    end else begin
      score_d = {1'b0, {(VAL_W-1){1'b1}}};
    end
  end

  assign sts_o.pipe_busy = s1_v_q || s2_v_q;
  assign res_valid_o     = res_v_q;
  assign res_o           = res_q;

endmodule

@@ rtl/dense_layer_forward.sv @@
// Top level of the dense layer forward block.
//
// Weight and bias writes are taken while idle and never raise busy. A feature
// element walks the ACT_CLASSES accumulators through the single weight RAM read port and
// one 16x16 multiplier, one class per cycle, then waits in ST_DRAIN for the last
// write-back; busy stays high meanwhile, so no new item is taken until the last one is
// through. An element marked last then walks ST_EMIT over the ACT_CLASSES classes;
// its results come out one per cycle in class order through the e1, e2 and result
// registers, with last_result on the final class.
// Results cannot be held off: each is valid for exactly one cycle. An element whose
// feature index is out of range skips accumulation. No clearing pass follows reset.
module dense_layer_forward
  import dlf_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  dlf_req_t req_i,
  output logic     res_valid_o,
  output dlf_res_t res_o
);

  logic     accept;
  dlf_ctl_t ctl;
  dlf_sts_t sts;

  assign accept = start && !busy;

  dlf_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .req_i    (req_i),
    .sts_i    (sts),
    .ctl_o    (ctl),
    .busy_o   (busy)
  );

  dlf_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .req_i       (req_i),
    .ctl_i       (ctl),
    .sts_o       (sts),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

endmodule

@@ rtl/dlf_checker.sv @@
// Port-level assertions on the result stream, bound to the top level.
module dlf_checker
  import dlf_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     start,
  input logic     busy,
  input dlf_req_t req_i,
  input logic     res_valid_o,
  input dlf_res_t res_o
);

  logic unused_in;
  assign unused_in = start ^ busy ^ (^req_i);

  a_burst_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_o.last_result |=> res_valid_o)
    else $error("result burst broken before last class");

  a_class_increments: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_o.last_result |=>
      res_o.class_index == CLS_W'($past(res_o.class_index) + 1'b1))
    else $error("class index does not advance by one");

  a_burst_starts_at_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_o) |-> res_o.class_index == '0)
    else $error("result burst does not start at class zero");

  a_last_on_final_class: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.last_result |-> res_o.class_index == CLS_W'(ACT_CLASSES - 1))
    else $error("last_result not on final class");

endmodule

bind dense_layer_forward dlf_checker u_dlf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .req_i       (req_i),
  .res_valid_o (res_valid_o),
  .res_o       (res_o)
);

@@ dv/tb_dense_layer_forward.sv @@
// Testbench for dense_layer_forward: directed table, weight-store preload, wrap run, random items.
module tb_dense_layer_forward;
  import dlf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 40;
  localparam int ITEMS_PER_PHASE = 100;
  localparam int WRAP_COUNT = 1024;
  localparam int DIR_ROWS = 19;

  typedef struct {
    dlf_req_t                item;
    bit                      typed;
    logic signed [VAL_W-1:0] score;
  } dir_row_t;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  dlf_req_t req_i = '0;
  logic     res_valid_o;
  dlf_res_t res_o;

  // sideband that travels with each item: typed-in score replaces the predicted one
  bit                      item_typed = 1'b0;
  logic signed [VAL_W-1:0] item_score = '0;

  logic signed [VAL_W-1:0] weight_mem [WDEPTH];
  logic signed [VAL_W-1:0] bias_mem [NUM_CLASSES];
  logic [ACC_W-1:0]        acc_mem [NUM_CLASSES];
  dlf_res_t                score_q [$];
  int                      err_cnt = 0;
  int                      cycle_cnt = 0;

  // rows 0,1,2,63 hold 1.0, -128.0, 0.5 and max weights; biases start at zero
  dir_row_t dir_tbl [DIR_ROWS] = '{
    '{'{REQ_FEATURE, 6'd0,  4'd0,  16'sh0100, 1'b1}, 1'b1, 16'sd256},
    '{'{REQ_FEATURE, 6'd2,  4'd0,  16'sh0001, 1'b1}, 1'b1, 16'sd1},     // half rounds up
    '{'{REQ_FEATURE, 6'd2,  4'd0,  16'shFFFF, 1'b1}, 1'b1, 16'sd0},     // minus half
    '{'{REQ_FEATURE, 6'd63, 4'd0,  16'sh7FFF, 1'b1}, 1'b1, 16'sh7FFF},
    '{'{REQ_FEATURE, 6'd63, 4'd0,  16'sh8000, 1'b1}, 1'b1, 16'sh8000},
    '{'{REQ_FEATURE, 6'd1,  4'd0,  16'sh8000, 1'b0}, 1'b0, 16'sd0},
    '{'{REQ_FEATURE, 6'd0,  4'd0,  16'sh0000, 1'b1}, 1'b1, 16'sh7FFF},
    '{'{REQ_UNUSED,  6'd63, 4'd15, 16'shFFFF, 1'b1}, 1'b0, 16'sd0},     // ignored
    '{'{REQ_FEATURE, 6'd0,  4'd0,  16'sh0000, 1'b1}, 1'b1, 16'sd0},
    '{'{REQ_WEIGHT,  6'd0,  4'd5,  16'sh0100, 1'b1}, 1'b0, 16'sd0},     // last mark ignored
    '{'{REQ_BIAS,    6'd0,  4'd0,  16'sh7FFF, 1'b0}, 1'b0, 16'sd0},
    '{'{REQ_BIAS,    6'd63, 4'd15, 16'sh8000, 1'b1}, 1'b0, 16'sd0},
    '{'{REQ_FEATURE, 6'd0,  4'd0,  16'sh7FFF, 1'b1}, 1'b0, 16'sd0},
    '{'{REQ_FEATURE, 6'd63, 4'd15, 16'sh7FFF, 1'b0}, 1'b0, 16'sd0},
    '{'{REQ_FEATURE, 6'd63, 4'd0,  16'sh8000, 1'b0}, 1'b0, 16'sd0},
    '{'{REQ_FEATURE, 6'd0,  4'd0,  16'sh0001, 1'b1}, 1'b0, 16'sd0},
    '{'{REQ_BIAS,    6'd0,  4'd0,  16'sh0000, 1'b0}, 1'b0, 16'sd0},
    '{'{REQ_BIAS,    6'd0,  4'd15, 16'sh0000, 1'b0}, 1'b0, 16'sd0},
    '{'{REQ_FEATURE, 6'd2,  4'd0,  16'sh0100, 1'b1}, 1'b1, 16'sd128}
  };

  dense_layer_forward u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    for (int k = 0; k < NUM_CLASSES; k++) acc_mem[k] = '0;
  end

  task automatic layer_predict(input dlf_req_t r, input bit typed,
                               input logic signed [VAL_W-1:0] typed_score);
    logic signed [PROD_W-1:0] prod;
    longint                   sum;
    longint                   q;
    dlf_res_t                 res;
    case (r.req_type)
      REQ_WEIGHT: begin
        if (r.feature_index < NUM_FEATURES && r.class_index_in < NUM_CLASSES)
          weight_mem[r.feature_index * NUM_CLASSES + r.class_index_in] = r.value;
      end
      REQ_BIAS: begin
        if (r.class_index_in < NUM_CLASSES) bias_mem[r.class_index_in] = r.value;
      end
      REQ_FEATURE: begin
        if (r.feature_index < NUM_FEATURES) begin
          for (int k = 0; k < NUM_CLASSES; k++) begin
            prod = r.value * weight_mem[r.feature_index * NUM_CLASSES + k];
            acc_mem[k] = acc_mem[k] + {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
          end
        end
        if (r.last_feature) begin
          for (int k = 0; k < ACT_CLASSES; k++) begin
            sum = longint'($signed(acc_mem[k])) + longint'(bias_mem[k]) * 256;
            q = (sum + 128) >>> FRAC_W;
            if (q > 32767) q = 32767;
            if (q < -32768) q = -32768;
            res.class_index = CLS_W'(k);
            res.score = typed ? typed_score : VAL_W'(q);
            res.last_result = (k == ACT_CLASSES - 1);
            score_q.push_back(res);
          end
          for (int k = 0; k < NUM_CLASSES; k++) acc_mem[k] = '0;
        end
      end
      default: ;
    endcase
  endtask

  // results are checked before the item of the same edge is predicted
  always @(posedge clk_i) begin
    dlf_res_t want;
    if (rst_ni) begin
      if (res_valid_o) begin
        if (score_q.size() == 0) begin
          err_cnt++;
          $display("%0t: result with nothing pending: exp none, got class %0d score %0d",
                   $time, res_o.class_index, res_o.score);
        end else begin
          want = score_q.pop_front();
          if (res_o.class_index !== want.class_index) begin
            err_cnt++;
            $display("%0t: class_index exp %0d got %0d", $time, want.class_index,
                     res_o.class_index);
          end
          if (res_o.score !== want.score) begin
            err_cnt++;
            $display("%0t: score class %0d exp %0d got %0d", $time, want.class_index,
                     want.score, res_o.score);
          end
          if (res_o.last_result !== want.last_result) begin
            err_cnt++;
            $display("%0t: last_result class %0d exp %0b got %0b", $time, want.class_index,
                     want.last_result, res_o.last_result);
          end
        end
      end
      if (start && !busy) layer_predict(req_i, item_typed, item_score);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send(input dlf_req_t r, input bit typed,
                      input logic signed [VAL_W-1:0] sc);
    req_i <= r;
    start <= 1'b1;
    item_typed <= typed;
    item_score <= sc;
    do @(posedge clk_i); while (busy);
  endtask

  // one extra edge so the last accepted item is already predicted
  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (score_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic dlf_req_t gen_item();
    dlf_req_t r;
    int       pick;
    pick = $urandom_range(99);
    r.feature_index = FEAT_W'($urandom);
    r.class_index_in = CLS_W'($urandom);
    r.last_feature = 1'($urandom);
    case ($urandom_range(7))
      0: r.value = 16'sh7FFF;
      1: r.value = 16'sh8000;
      2: r.value = 16'sh0000;
      3: r.value = 16'shFFFF;
      default: r.value = VAL_W'($urandom);
    endcase
    if (pick < 60) begin
      r.req_type = REQ_FEATURE;
      r.last_feature = ($urandom_range(4) == 0);
    end else if (pick < 80) begin
      r.req_type = REQ_WEIGHT;
    end else if (pick < 90) begin
      r.req_type = REQ_BIAS;
    end else begin
      r.req_type = REQ_UNUSED;
    end
    return r;
  endfunction

  initial begin
    int       idle_pct [4] = '{0, 68, 24, 0};
    dlf_req_t r;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // fill both stores so no read ever hits an unwritten entry
    for (int f = 0; f < NUM_FEATURES; f++) begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        r = '{REQ_WEIGHT, FEAT_W'(f), CLS_W'(c), VAL_W'($urandom), 1'b0};
        case (f)
          0: r.value = 16'sh0100;
          1: r.value = 16'sh8000;
          2: r.value = 16'sh0080;
          NUM_FEATURES - 1: r.value = 16'sh7FFF;
          default: ;
        endcase
        send(r, 1'b0, '0);
      end
    end
    for (int c = 0; c < NUM_CLASSES; c++)
      send('{REQ_BIAS, FEAT_W'($urandom), CLS_W'(c), 16'sh0000, 1'b0}, 1'b0, '0);

    foreach (dir_tbl[i]) send(dir_tbl[i].item, dir_tbl[i].typed, dir_tbl[i].score);

    // 1024 products of 2^30 wrap the accumulators back to zero
    for (int i = 0; i < WRAP_COUNT; i++)
      send('{REQ_FEATURE, 6'd1, 4'd0, 16'sh8000, 1'b0}, 1'b0, '0);
    send('{REQ_FEATURE, 6'd0, 4'd0, 16'sh0100, 1'b1}, 1'b1, 16'sd256);
    drain();

    foreach (idle_pct[p]) begin
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        while ($urandom_range(99) < idle_pct[p]) begin
          start <= 1'b0;
          @(posedge clk_i);
        end
        send(gen_item(), 1'b0, '0);
      end
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (score_q.size() != 0) begin
      err_cnt++;
      $display("%0t: pending results exp 0 got %0d", $time, score_q.size());
    end
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
